/* rtl/core/contact_impedance_enable_gate_unit_macros.svh */
// Assertion macros shared by the contact impedance enable gate RTL.
`ifndef CONTACT_IMPEDANCE_ENABLE_GATE_UNIT_MACROS_SVH
`define CONTACT_IMPEDANCE_ENABLE_GATE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define CIGU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cigu assertion failed");
// Next-cycle implication, disabled while in reset
`define CIGU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cigu assertion failed");
`else
`define CIGU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CIGU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/cigu_pkg.sv */
// Shared types, constants and helpers of the contact impedance enable gate.
package cigu_pkg;

  localparam int NumChan = 4;
  localparam int ChanW   = 2;

  // item kinds
  localparam logic KindRequest = 1'b0;
  localparam logic KindDone    = 1'b1;

  // electrode channel
  localparam logic [ChanW-1:0] ElecChan = 2'd3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgMaxOhm    = 2'd0,
    CfgMagic     = 2'd1,
    CfgFlag      = 2'd2,
    CfgStatusBit = 2'd3
  } cfg_idx_t;

  localparam logic [31:0] MaxOhmReset    = 32'd10000;
  localparam logic [7:0]  MagicReset     = 8'd165;
  localparam logic [7:0]  FlagReset      = 8'd1;
  localparam logic [2:0]  StatusBitReset = 3'd0;

  // ohm -> kohm*100 : (ohm*100 + 500) / 1000 == (ohm + 5) / 10
  localparam int          KohmScale   = 100;
  localparam int          KohmRoundW  = 500 / KohmScale;
  localparam int          KohmDivisor = 1000 / KohmScale;
  localparam logic [15:0] KohmMax     = 16'hFFFF;
  // first ohm value whose reading clamps
  localparam logic [31:0] SatOhm      = 32'((65536 * KohmDivisor) - KohmRoundW);
  localparam int          RdgW        = 20;              // ohm + round below SatOhm
  localparam int          RecipShift  = 23;
  localparam logic [RdgW-1:0] Recip   = RdgW'(((1 << RecipShift) + KohmDivisor - 1) / KohmDivisor);

  // queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  typedef struct packed {
    logic [31:0] max_ohm;
    logic [7:0]  magic;
    logic [7:0]  flag;
    logic [2:0]  status_bit;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [NumChan-1:0] mask;
    logic [ChanW-1:0]  channel;
    logic [31:0]       impedance;
    logic [31:0]       elec_a;
    logic [31:0]       elec_b;
    logic [NumChan-1:0] granted;
    logic [7:0]        status;
    logic [3:0]        slot;
  } in_item_t;

  // classified word from front to back
  typedef struct packed {
    logic [NumChan-1:0] granted;
    logic [7:0]         status;
    logic [3:0]         slot;
    logic [NumChan-1:0] pending;
    logic               valid;
    logic               load;
    logic               sat_a;
    logic               sat_b;
    logic [RdgW-1:0]    x_a;
    logic [RdgW-1:0]    x_b;
  } cmd_t;

  typedef struct packed {
    logic [NumChan-1:0] granted;
    logic [7:0]         status;
    logic [3:0]         slot;
    logic [NumChan-1:0] pending;
    logic               valid;
    logic [7:0]         magic;
    logic [7:0]         flags;
    logic [15:0]        rdg_a;
    logic [15:0]        rdg_b;
    logic [15:0]        checksum;
  } res_t;

  // fault slot per channel
  function automatic logic [3:0] slot_of_chan(input logic [ChanW-1:0] ch);
    logic [3:0] s;
    case (ch)
      2'd0:    s = 4'd7;
      2'd1:    s = 4'd6;
      2'd2:    s = 4'd5;
      default: s = 4'd10;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/cigu_cmd_queue.sv */
// Short queue of classified words between front and back.
`include "contact_impedance_enable_gate_unit_macros.svh"
module cigu_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  cigu_pkg::cmd_t wr_word,
  input  logic           rd_en,
  output cigu_pkg::cmd_t rd_word,
  output logic           full,
  output logic           empty
);

  cigu_pkg::cmd_t                   mem_r [cigu_pkg::QDepth];
  logic [cigu_pkg::QPtrW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [cigu_pkg::QCntW-1:0]       cnt_r, cnt_nxt;
  logic                             do_wr, do_rd;

  assign full    = (cnt_r == cigu_pkg::QCntW'(cigu_pkg::QDepth));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_word = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

  `CIGU_ASSERT_NXT(a_cmdq_push_counts, clk, rst_n, do_wr && !do_rd, cnt_r == $past(cnt_r) + 1'b1)
  `CIGU_ASSERT_IMP(a_cmdq_bound, clk, rst_n, 1'b1, cnt_r <= cigu_pkg::QCntW'(cigu_pkg::QDepth))

endmodule

/* rtl/core/cigu_front.sv */
// Front end: tracks pending channels and report validity, classifies each item.
`include "contact_impedance_enable_gate_unit_macros.svh"
module cigu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  cigu_pkg::cfg_t     cfg,
  input  logic               accept,
  input  cigu_pkg::in_item_t in_item,
  output cigu_pkg::cmd_t     cmd
);

  logic [cigu_pkg::NumChan-1:0] pend_r, pend_nxt;
  logic                         valid_r, valid_nxt;
  logic                         over;
  logic [7:0]                   sbit;
  logic [31:0]                  a_rnd, b_rnd;

  assign over  = (in_item.impedance > cfg.max_ohm);
  assign sbit  = 8'd1 << cfg.status_bit;
  assign a_rnd = in_item.elec_a + 32'(cigu_pkg::KohmRoundW);
  assign b_rnd = in_item.elec_b + 32'(cigu_pkg::KohmRoundW);

  // classify and work out gate outputs
  always_comb begin
    pend_nxt    = pend_r;
    valid_nxt   = valid_r;
    cmd.granted = in_item.granted;
    cmd.status  = in_item.status;
    cmd.slot    = in_item.slot;
    cmd.load    = 1'b0;
    if (in_item.kind == cigu_pkg::KindRequest) begin
      pend_nxt = pend_r | in_item.mask;
      if (in_item.mask[cigu_pkg::ElecChan]) begin
        valid_nxt = 1'b0;
      end
    end else if (pend_r[in_item.channel]) begin
      pend_nxt[in_item.channel] = 1'b0;
      if (over) begin
        cmd.granted[in_item.channel] = 1'b0;
        cmd.status = in_item.status | sbit;
        cmd.slot   = cigu_pkg::slot_of_chan(in_item.channel);
      end else begin
        cmd.status = in_item.status & ~sbit;
      end
      if (in_item.channel == cigu_pkg::ElecChan) begin
        valid_nxt = 1'b1;
        cmd.load  = 1'b1;
      end
    end
    cmd.pending = pend_nxt;
    cmd.valid   = valid_nxt;
    cmd.sat_a   = (in_item.elec_a >= cigu_pkg::SatOhm);
    cmd.sat_b   = (in_item.elec_b >= cigu_pkg::SatOhm);
    cmd.x_a     = a_rnd[cigu_pkg::RdgW-1:0];
    cmd.x_b     = b_rnd[cigu_pkg::RdgW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  `CIGU_ASSERT_NXT(a_req_elec_drops_valid, clk, rst_n, accept && in_item.kind == cigu_pkg::KindRequest && in_item.mask[cigu_pkg::ElecChan], !valid_r)
  `CIGU_ASSERT_NXT(a_idle_done_keeps_pend, clk, rst_n, accept && in_item.kind == cigu_pkg::KindDone && !pend_r[in_item.channel], pend_r == $past(pend_r))

endmodule

/* rtl/core/cigu_back.sv */
// Back end: converts electrode readings, builds the report, holds the result queue.
`include "contact_impedance_enable_gate_unit_macros.svh"
module cigu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cigu_pkg::cfg_t cfg,
  input  cigu_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  input  logic           res_pop,
  output logic           res_empty,
  output cigu_pkg::res_t res
);

  // stage 1: reciprocal multiply
  logic                 s1_vld_r;
  cigu_pkg::cmd_t       s1_cmd_r;
  logic [15:0]          s1_qa_r, s1_qb_r;
  logic [2*cigu_pkg::RdgW-1:0] prod_a, prod_b;

  // stored readings
  logic [15:0]          rdg_a_r, rdg_b_r;
  logic [15:0]          new_a, new_b, use_a, use_b;
  cigu_pkg::res_t       res_nxt;

  // result queue
  cigu_pkg::res_t              oq_r [cigu_pkg::QDepth];
  logic [cigu_pkg::QPtrW-1:0]  oq_wp_r, oq_rp_r;
  logic [cigu_pkg::QCntW-1:0]  oq_cnt_r;
  logic                        oq_full, s1_move, oq_rd;

  assign oq_full   = (oq_cnt_r == cigu_pkg::QCntW'(cigu_pkg::QDepth));
  assign res_empty = (oq_cnt_r == '0);
  assign oq_rd     = res_pop && !res_empty;
  assign s1_move   = s1_vld_r && !oq_full;
  assign cmd_pop   = !cmd_empty && (!s1_vld_r || s1_move);
  assign res       = oq_r[oq_rp_r];

  assign prod_a = {{cigu_pkg::RdgW{1'b0}}, cmd.x_a} * {{cigu_pkg::RdgW{1'b0}}, cigu_pkg::Recip};
  assign prod_b = {{cigu_pkg::RdgW{1'b0}}, cmd.x_b} * {{cigu_pkg::RdgW{1'b0}}, cigu_pkg::Recip};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (cmd_pop) begin
      s1_vld_r <= 1'b1;
    end else if (s1_move) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_cmd_r <= cmd;
      s1_qa_r  <= prod_a[cigu_pkg::RecipShift+15:cigu_pkg::RecipShift];
      s1_qb_r  <= prod_b[cigu_pkg::RecipShift+15:cigu_pkg::RecipShift];
    end
  end

  // stage 2: clamp, pick readings, checksum
  always_comb begin
    new_a = s1_cmd_r.sat_a ? cigu_pkg::KohmMax : s1_qa_r;
    new_b = s1_cmd_r.sat_b ? cigu_pkg::KohmMax : s1_qb_r;
    use_a = s1_cmd_r.load ? new_a : rdg_a_r;
    use_b = s1_cmd_r.load ? new_b : rdg_b_r;
    res_nxt.granted = s1_cmd_r.granted;
    res_nxt.status  = s1_cmd_r.status;
    res_nxt.slot    = s1_cmd_r.slot;
    res_nxt.pending = s1_cmd_r.pending;
    res_nxt.valid   = s1_cmd_r.valid;
    if (s1_cmd_r.valid) begin
      res_nxt.magic    = cfg.magic;
      res_nxt.flags    = cfg.flag;
      res_nxt.rdg_a    = use_a;
      res_nxt.rdg_b    = use_b;
      res_nxt.checksum = 16'(cfg.magic) + 16'(cfg.flag) + 16'(use_a[7:0]) + 16'(use_a[15:8])
                       + 16'(use_b[7:0]) + 16'(use_b[15:8]);
    end else begin
      res_nxt.magic    = '0;
      res_nxt.flags    = '0;
      res_nxt.rdg_a    = '0;
      res_nxt.rdg_b    = '0;
      res_nxt.checksum = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdg_a_r <= '0;
      rdg_b_r <= '0;
    end else if (s1_move && s1_cmd_r.load) begin
      rdg_a_r <= new_a;
      rdg_b_r <= new_b;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (s1_move) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (oq_rd) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      if (s1_move && !oq_rd) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_rd && !s1_move) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      oq_r[oq_wp_r] <= res_nxt;
    end
  end

  `CIGU_ASSERT_IMP(a_oq_no_overflow, clk, rst_n, s1_move, !oq_full)
  `CIGU_ASSERT_NXT(a_s1_holds_on_stall, clk, rst_n, s1_vld_r && oq_full, s1_vld_r && s1_cmd_r == $past(s1_cmd_r))

endmodule

/* rtl/core/contact_impedance_enable_gate_unit.sv */
// An accepted word goes through the command queue, stage 1 and the result queue to the
// result ports. Throughput: one word per cycle while the result queue is not full, set
// by the front classifier and the one-multiply conversion stage in the back end.
// Reset (rst_n low at a clock edge) empties both queues, clears pending channels
// and report validity, and loads the configuration registers with their defaults.
// Top level of the contact impedance enable gate.
module contact_impedance_enable_gate_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [3:0]  in_requested_channels,
  input  logic [1:0]  in_channel,
  input  logic [31:0] in_impedance_ohm,
  input  logic [31:0] in_electrode_a_ohm,
  input  logic [31:0] in_electrode_b_ohm,
  input  logic [3:0]  in_granted_in,
  input  logic [7:0]  in_status_in,
  input  logic [3:0]  in_fault_slot_in,
  // result words
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_granted_out,
  output logic [7:0]  out_status_out,
  output logic [3:0]  out_fault_slot_out,
  output logic [3:0]  out_pending_channels,
  output logic        out_report_valid,
  output logic [7:0]  out_report_magic,
  output logic [7:0]  out_report_flags,
  output logic [15:0] out_electrode_a_kohm_x100,
  output logic [15:0] out_electrode_b_kohm_x100,
  output logic [15:0] out_report_checksum,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cigu_pkg::cfg_t     cfg_r;
  cigu_pkg::in_item_t in_item;
  cigu_pkg::cmd_t     cmd_in, cmd_out;
  cigu_pkg::res_t     res;
  logic               accept, cmd_full, cmd_empty, cmd_pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_ohm    <= cigu_pkg::MaxOhmReset;
      cfg_r.magic      <= cigu_pkg::MagicReset;
      cfg_r.flag       <= cigu_pkg::FlagReset;
      cfg_r.status_bit <= cigu_pkg::StatusBitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cigu_pkg::cfg_idx_t'(cfg_index))
        cigu_pkg::CfgMaxOhm:    cfg_r.max_ohm    <= cfg_data;
        cigu_pkg::CfgMagic:     cfg_r.magic      <= cfg_data[7:0];
        cigu_pkg::CfgFlag:      cfg_r.flag       <= cfg_data[7:0];
        cigu_pkg::CfgStatusBit: cfg_r.status_bit <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // input word
  assign in_item.kind      = in_kind;
  assign in_item.mask      = in_requested_channels;
  assign in_item.channel   = in_channel;
  assign in_item.impedance = in_impedance_ohm;
  assign in_item.elec_a    = in_electrode_a_ohm;
  assign in_item.elec_b    = in_electrode_b_ohm;
  assign in_item.granted   = in_granted_in;
  assign in_item.status    = in_status_in;
  assign in_item.slot      = in_fault_slot_in;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  cigu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .in_item (in_item),
    .cmd     (cmd_in)
  );

  cigu_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_word (cmd_in),
    .rd_en   (cmd_pop),
    .rd_word (cmd_out),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  cigu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  // result word
  assign out_granted_out           = res.granted;
  assign out_status_out            = res.status;
  assign out_fault_slot_out        = res.slot;
  assign out_pending_channels      = res.pending;
  assign out_report_valid          = res.valid;
  assign out_report_magic          = res.magic;
  assign out_report_flags          = res.flags;
  assign out_electrode_a_kohm_x100 = res.rdg_a;
  assign out_electrode_b_kohm_x100 = res.rdg_b;
  assign out_report_checksum       = res.checksum;

endmodule

/* bench/cigu_checker.sv */
// Checker for the contact impedance enable gate: predicts each result word and compares it.
`timescale 1ns / 100ps

module cigu_checker
  import cigu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // input channel
  input  logic     push,
  input  logic     full,
  input  in_item_t in_word,
  // result channel
  input  logic     empty,
  input  logic     pop,
  input  res_t     got_word,
  // configuration channel
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // to the top
  output int       mismatches,
  output int       due_count
);

  // fault slot per channel, channel 0 in the low nibble
  localparam logic [15:0] FaultSlots = {4'd10, 4'd5, 4'd6, 4'd7};
  // ohm to kohm*100 conversion terms
  localparam logic [63:0] OhmScale   = 64'd100;
  localparam logic [63:0] OhmRound   = 64'd500;
  localparam logic [63:0] OhmDivide  = 64'd1000;
  localparam logic [63:0] ReadingMax = 64'hFFFF;

  // predicted gate state and register copies
  logic [31:0] lim_ohm;
  logic [7:0]  magic_r;
  logic [7:0]  flag_r;
  logic [2:0]  sbit_pos;
  logic [3:0]  pend_mask;
  logic [15:0] rdg_a;
  logic [15:0] rdg_b;
  logic        rdg_ok;

  res_t gate_results_due[$];
  int   words_seen;

  initial begin
    mismatches = 0;
    due_count  = 0;
    words_seen = 0;
  end

  // exact rounding, clamped to 16 bits
  function automatic logic [15:0] ohm_to_reading(input logic [31:0] ohm);
    logic [63:0] v;
    v = ({32'd0, ohm} * OhmScale + OhmRound) / OhmDivide;
    if (v > ReadingMax) v = ReadingMax;
    return v[15:0];
  endfunction

  // gate update for one accepted input word
  task automatic gate_predict(input in_item_t w, output res_t r);
    logic [7:0] sbit;
    sbit      = 8'd1 << sbit_pos;
    r.granted = w.granted;
    r.status  = w.status;
    r.slot    = w.slot;
    if (w.kind == KindRequest) begin
      pend_mask = pend_mask | w.mask;
      if (w.mask[ElecChan]) rdg_ok = 1'b0;
    end else if (pend_mask[w.channel]) begin
      pend_mask[w.channel] = 1'b0;
      if (w.impedance > lim_ohm) begin
        r.granted[w.channel] = 1'b0;
        r.status = r.status | sbit;
        r.slot   = FaultSlots[w.channel*4 +: 4];
      end else begin
        r.status = r.status & ~sbit;
      end
      if (w.channel == ElecChan) begin
        rdg_a  = ohm_to_reading(w.elec_a);
        rdg_b  = ohm_to_reading(w.elec_b);
        rdg_ok = 1'b1;
      end
    end
    r.pending = pend_mask;
    r.valid   = rdg_ok;
    if (rdg_ok) begin
      r.magic    = magic_r;
      r.flags    = flag_r;
      r.rdg_a    = rdg_a;
      r.rdg_b    = rdg_b;
      r.checksum = {8'd0, magic_r} + {8'd0, flag_r} + {8'd0, rdg_a[7:0]}
                 + {8'd0, rdg_a[15:8]} + {8'd0, rdg_b[7:0]} + {8'd0, rdg_b[15:8]};
    end else begin
      r.magic    = '0;
      r.flags    = '0;
      r.rdg_a    = '0;
      r.rdg_b    = '0;
      r.checksum = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at result word %0d: %s", words_seen, msg);
    mismatches++;
  endtask

  task automatic note_field(input string name, input logic [31:0] got,
                            input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // watch all three channels
  always @(posedge clk) begin
    res_t r;
    if (!rst_n) begin
      lim_ohm   = MaxOhmReset;
      magic_r   = MagicReset;
      flag_r    = FlagReset;
      sbit_pos  = StatusBitReset;
      pend_mask = '0;
      rdg_a     = '0;
      rdg_b     = '0;
      rdg_ok    = 1'b0;
      gate_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgMaxOhm:    lim_ohm  = cfg_data;
          CfgMagic:     magic_r  = cfg_data[7:0];
          CfgFlag:      flag_r   = cfg_data[7:0];
          CfgStatusBit: sbit_pos = cfg_data[2:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        gate_predict(in_word, r);
        gate_results_due.push_back(r);
      end
      if (pop && !empty) begin
        if (gate_results_due.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          r = gate_results_due.pop_front();
          note_field("granted_out", got_word.granted, r.granted);
          note_field("status_out", got_word.status, r.status);
          note_field("fault_slot_out", got_word.slot, r.slot);
          note_field("pending_channels", got_word.pending, r.pending);
          note_field("report_valid", got_word.valid, r.valid);
          note_field("report_magic", got_word.magic, r.magic);
          note_field("report_flags", got_word.flags, r.flags);
          note_field("electrode_a_kohm_x100", got_word.rdg_a, r.rdg_a);
          note_field("electrode_b_kohm_x100", got_word.rdg_b, r.rdg_b);
          note_field("report_checksum", got_word.checksum, r.checksum);
        end
        words_seen++;
      end
    end
    // published with a nonblocking assignment so the top never races the update
    due_count <= gate_results_due.size();
  end

endmodule

/* bench/tb.sv */
// Testbench top for the contact impedance enable gate: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import cigu_pkg::*;

  localparam int RunLimitNs    = 2_000_000;
  localparam int HoldOffCycles = 80;
  localparam int TailCycles    = 16;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        pop;
  in_item_t    stim;
  logic        cfg_valid;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  logic        full;
  logic        empty;
  logic        cfg_ready;
  logic [3:0]  out_granted_out;
  logic [7:0]  out_status_out;
  logic [3:0]  out_fault_slot_out;
  logic [3:0]  out_pending_channels;
  logic        out_report_valid;
  logic [7:0]  out_report_magic;
  logic [7:0]  out_report_flags;
  logic [15:0] out_electrode_a_kohm_x100;
  logic [15:0] out_electrode_b_kohm_x100;
  logic [15:0] out_report_checksum;

  int mismatches;
  int due_count;

  // threshold currently loaded, steers impedance picks
  logic [31:0] cur_max;
  // sender burst state
  int burst_left;
  // receiver hold-off handshake: top bumps requests, receiver catches up
  int hold_requests = 0;
  int hold_served;
  int rx_mode;
  int rx_left;

  contact_impedance_enable_gate_unit uut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .push                      (push),
    .full                      (full),
    .in_kind                   (stim.kind),
    .in_requested_channels     (stim.mask),
    .in_channel                (stim.channel),
    .in_impedance_ohm          (stim.impedance),
    .in_electrode_a_ohm        (stim.elec_a),
    .in_electrode_b_ohm        (stim.elec_b),
    .in_granted_in             (stim.granted),
    .in_status_in              (stim.status),
    .in_fault_slot_in          (stim.slot),
    .empty                     (empty),
    .pop                       (pop),
    .out_granted_out           (out_granted_out),
    .out_status_out            (out_status_out),
    .out_fault_slot_out        (out_fault_slot_out),
    .out_pending_channels      (out_pending_channels),
    .out_report_valid          (out_report_valid),
    .out_report_magic          (out_report_magic),
    .out_report_flags          (out_report_flags),
    .out_electrode_a_kohm_x100 (out_electrode_a_kohm_x100),
    .out_electrode_b_kohm_x100 (out_electrode_b_kohm_x100),
    .out_report_checksum       (out_report_checksum),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data)
  );

  cigu_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_word    (stim),
    .empty      (empty),
    .pop        (pop),
    .got_word   ({out_granted_out, out_status_out, out_fault_slot_out,
                  out_pending_channels, out_report_valid, out_report_magic,
                  out_report_flags, out_electrode_a_kohm_x100,
                  out_electrode_b_kohm_x100, out_report_checksum}),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .due_count  (due_count)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #(RunLimitNs);
    $display("status: fail");
    $finish;
  end

  // receiver: runs of steady, random and sparse pops, plus requested hold-offs
  initial begin
    pop         = 1'b0;
    hold_served = 0;
    rx_left     = 0;
    rx_mode     = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        pop <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(4, 50);
      end
      rx_left--;
      case (rx_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic in_item_t make_word(input logic kind, input logic [3:0] mask,
                                         input logic [1:0] chan, input logic [31:0] z,
                                         input logic [31:0] ea, input logic [31:0] eb,
                                         input logic [3:0] g, input logic [7:0] s,
                                         input logic [3:0] f);
    in_item_t w;
    w.kind      = kind;
    w.mask      = mask;
    w.channel   = chan;
    w.impedance = z;
    w.elec_a    = ea;
    w.elec_b    = eb;
    w.granted   = g;
    w.status    = s;
    w.slot      = f;
    return w;
  endfunction

  // impedance near the threshold, anywhere, small, or at the extremes
  function automatic logic [31:0] pick_ohm();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = cur_max + $urandom_range(0, 4) - 32'd2;
      1:       v = $urandom;
      2:       v = $urandom_range(0, 30000);
      default: v = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
    endcase
    return v;
  endfunction

  // electrode value: small, around the clamp point, anywhere, or mid range
  function automatic logic [31:0] pick_elec();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 1000);
      1:       v = $urandom_range(655340, 655370);
      2:       v = $urandom;
      default: v = $urandom_range(0, 700000);
    endcase
    return v;
  endfunction

  function automatic in_item_t rand_word(input logic kind, input logic [3:0] mask,
                                         input logic [1:0] chan);
    return make_word(kind, mask, chan, pick_ohm(), pick_elec(), pick_elec(),
                     4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)));
  endfunction

  // offer one word, wait for it to be taken, then maybe idle between bursts
  task automatic offer_word(input in_item_t w);
    int gap;
    stim <= w;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // sender stops until every expected word has come back
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all four registers, only while the block is idle
  task automatic load_config(input logic [31:0] max_ohm, input logic [7:0] magic,
                             input logic [7:0] flag, input logic [2:0] sbit);
    write_reg(CfgMaxOhm, max_ohm);
    write_reg(CfgMagic, {24'd0, magic});
    write_reg(CfgFlag, {24'd0, flag});
    write_reg(CfgStatusBit, {29'd0, sbit});
    cfg_valid <= 1'b0;
    cur_max = max_ohm;
  endtask

  // mostly request-then-complete sequences, some noise and skipped completions
  task automatic random_phase(input int n_items);
    int done;
    int start;
    int step;
    int ch;
    logic [3:0] mask;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        offer_word(rand_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                             2'($urandom_range(0, 3))));
        done++;
      end else begin
        mask = 4'($urandom_range(1, 15));
        offer_word(rand_word(KindRequest, mask, 2'($urandom_range(0, 3))));
        done++;
        start = $urandom_range(0, 3);
        step  = $urandom_range(0, 1) ? 1 : 3;
        for (int k = 0; k < 4; k++) begin
          ch = (start + k * step) % 4;
          if (mask[ch] && $urandom_range(0, 9) != 0) begin
            offer_word(rand_word(KindDone, 4'($urandom_range(0, 15)), 2'(ch)));
            done++;
          end
          if ($urandom_range(0, 7) == 0) begin
            offer_word(rand_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                 2'($urandom_range(0, 3))));
            done++;
          end
        end
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n      = 1'b0;
    push       = 1'b0;
    stim       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cur_max    = MaxOhmReset;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under reset register values
    // empty mask with all-ones gate inputs
    offer_word(make_word(KindRequest, 4'h0, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 4'hF, 8'hFF, 4'hF));
    // completion of a channel that is not pending
    offer_word(make_word(KindDone, 4'hF, 2'd0, 32'hFFFF_FFFF, 32'd0, 32'd0,
                         4'hF, 8'hFF, 4'hF));
    offer_word(make_word(KindRequest, 4'hF, 2'd0, 32'd0, 32'd0, 32'd0, 4'h0, 8'h00, 4'h0));
    // repeat request of a pending channel
    offer_word(make_word(KindRequest, 4'h1, 2'd1, 32'd0, 32'd0, 32'd0, 4'hF, 8'h5A, 4'h3));
    // exactly at the threshold passes
    offer_word(make_word(KindDone, 4'h0, 2'd0, 32'd10000, 32'd0, 32'd0, 4'hF, 8'hFF, 4'h0));
    offer_word(make_word(KindDone, 4'h0, 2'd1, 32'd10001, 32'd0, 32'd0, 4'hF, 8'h00, 4'h0));
    offer_word(make_word(KindDone, 4'hF, 2'd2, 32'hFFFF_FFFF, 32'd0, 32'd0,
                         4'h0, 8'h00, 4'hF));
    // electrode readings at zero and clamped
    offer_word(make_word(KindDone, 4'h0, 2'd3, 32'd0, 32'd0, 32'hFFFF_FFFF,
                         4'hF, 8'hFF, 4'h3));
    offer_word(make_word(KindDone, 4'h0, 2'd3, 32'hFFFF_FFFF, 32'd5, 32'd5,
                         4'hF, 8'h81, 4'h1));
    offer_word(make_word(KindRequest, 4'h8, 2'd0, 32'd0, 32'd0, 32'd0, 4'hA, 8'h11, 4'h2));
    // failing electrode channel, readings just below and at the clamp point
    offer_word(make_word(KindDone, 4'h0, 2'd3, 32'd10001, 32'd655354, 32'd655355,
                         4'hF, 8'h00, 4'h0));
    offer_word(make_word(KindRequest, 4'h8, 2'd3, 32'd0, 32'd0, 32'd0, 4'h5, 8'h22, 4'h8));
    // rounding down and up
    offer_word(make_word(KindDone, 4'h7, 2'd3, 32'd9999, 32'd4, 32'd5, 4'hC, 8'hF0, 4'hC));
    offer_word(make_word(KindRequest, 4'h7, 2'd2, 32'd0, 32'd0, 32'd0, 4'h3, 8'h0F, 4'h9));
    offer_word(make_word(KindDone, 4'h0, 2'd0, 32'd0, 32'd0, 32'd0, 4'hF, 8'h01, 4'h6));
    offer_word(make_word(KindDone, 4'h0, 2'd1, 32'd0, 32'd0, 32'd0, 4'hF, 8'h03, 4'h5));
    offer_word(make_word(KindDone, 4'h0, 2'd2, 32'd10000, 32'd0, 32'd0, 4'hF, 8'hFE, 4'h4));
    offer_word(make_word(KindRequest, 4'h8, 2'd1, 32'd0, 32'd0, 32'd0, 4'h6, 8'h44, 4'h7));
    offer_word(make_word(KindDone, 4'h0, 2'd3, 32'd12345, 32'd14, 32'd15, 4'h9, 8'h99, 4'hE));
    offer_word(make_word(KindDone, 4'h0, 2'd3, 32'd0, 32'd1, 32'd2, 4'hF, 8'hFF, 4'hF));
    wait_drained();

    // register settings: low extremes, high extremes, then random ones
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_config(32'd0, 8'h00, 8'h00, 3'd7);
        1: load_config(32'hFFFF_FFFF, 8'hFF, 8'hFF, 3'd0);
        default: load_config($urandom_range(0, 1) ? $urandom_range(0, 50000) : $urandom,
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             3'($urandom_range(0, 7)));
      endcase
      if (ph == 3) begin
        // long receiver hold-off while words keep coming, fills the block
        hold_requests++;
        random_phase(30);
      end
      random_phase(65);
      wait_drained();
    end

    // let any stray word show up before the verdict
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && due_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/cigu_pkg.sv
rtl/core/cigu_cmd_queue.sv
rtl/core/cigu_front.sv
rtl/core/cigu_back.sv
rtl/core/contact_impedance_enable_gate_unit.sv
bench/cigu_checker.sv
bench/tb.sv
